// ===== src/pip_pkg.sv =====
// shared codes and fixed port widths for the point-in-polygon test block
// no dependencies

package pip_pkg;

   localparam int SLOT_W = 4;
   localparam int CSR_W  = 5;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [CSR_W-1:0] VCOUNT_RESET = CSR_W'(1);

endpackage

// ===== src/point_in_polygon_test.sv =====
// point-in-polygon test by ray casting over a stored vertex table
// depends on pip_pkg

// A request is taken when start is high and busy is low. A vertex write request
// (req_type low) stores its vertex in that same cycle, returns nothing and never
// raises busy. A query request walks the N stored edges (N is csr_vertex_count,
// capped at MAX_VERTICES) and holds busy as it reads vertex 0 in ST_FIRST, then
// takes each edge through ST_EDGE, ST_MUL1, ST_MUL2 and ST_DECIDE, because a
// single shared signed multiplier forms the two cross products of each edge one
// after the other and the table has one registered read port. The answer appears
// on rsp_inside_res with rsp_valid high for one cycle, as busy falls; with a zero
// count, the cycle after the request. The receiver cannot stall the result, so
// it must take it when rsp_valid is high. A new request may be taken in the same
// cycle a result is shown. The vertex count may only be written while idle.

module point_in_polygon_test #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [pip_pkg::SLOT_W-1:0]    req_vertex_index,
   input  logic signed [COORD_BITS-1:0]  req_coord_x,
   input  logic signed [COORD_BITS-1:0]  req_coord_y,
   output logic                          rsp_valid,
   output logic                          rsp_inside_res,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pip_pkg::CSR_W-1:0]     csr_vertex_count
);

   import pip_pkg::*;

   localparam int CW    = COORD_BITS;
   localparam int DW    = COORD_BITS + 1;
   localparam int PW    = 2 * DW;
   localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int IDX_W = $clog2(MAX_VERTICES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_EDGE,
      ST_MUL1,
      ST_MUL2,
      ST_DECIDE
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  vcount_ff, vcount_in;
   logic              inside_ff, inside_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_inside_ff, rsp_inside_in;

   // vertex table, x in the upper half
   logic [2*CW-1:0]   vtx_mem [MAX_VERTICES];
   logic [2*CW-1:0]   rd_data_ff;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;

   logic signed [CW-1:0] px_ff, py_ff;
   logic signed [CW-1:0] first_x_ff, first_y_ff;
   logic signed [CW-1:0] prev_x_ff, prev_y_ff;
   logic signed [DW-1:0] a_ff, b_ff, c_ff, d_ff;
   logic                 span_ff, vert_ff, dypos_ff, last_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;

   logic                 req_accept;
   logic                 last_edge;
   logic signed [CW-1:0] rd_x, rd_y, cur_x, cur_y;
   logic signed [CW-1:0] ylo, yhi, xhi;
   logic signed [DW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_out;
   logic                 toggle;

   assign req_accept = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

   assign wr_en = req_accept && (req_type == REQ_WRITE)
                  && (int'(req_vertex_index) < MAX_VERTICES);

   always_comb begin
      if ((state_ff == ST_IDLE) || (idx_ff >= vcount_ff)) begin
         rd_addr = '0;
      end else begin
         rd_addr = idx_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vtx_mem[AW'(req_vertex_index)] <= {req_coord_x, req_coord_y};
      end
      rd_data_ff <= vtx_mem[rd_addr];
   end

   assign rd_x = $signed(rd_data_ff[2*CW-1:CW]);
   assign rd_y = $signed(rd_data_ff[CW-1:0]);

   // closing edge returns to the first vertex
   assign last_edge = (idx_ff == vcount_ff);
   assign cur_x     = last_edge ? first_x_ff : rd_x;
   assign cur_y     = last_edge ? first_y_ff : rd_y;

   assign ylo = (prev_y_ff < cur_y) ? prev_y_ff : cur_y;
   assign yhi = (prev_y_ff < cur_y) ? cur_y : prev_y_ff;
   assign xhi = (prev_x_ff < cur_x) ? cur_x : prev_x_ff;

   // shared multiplier
   assign mul_a   = (state_ff == ST_MUL1) ? a_ff : c_ff;
   assign mul_b   = (state_ff == ST_MUL1) ? b_ff : d_ff;
   assign mul_out = mul_a * mul_b;

   assign toggle = span_ff && (vert_ff || (dypos_ff ? (p1_ff <= p2_ff) : (p1_ff >= p2_ff)));

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      inside_in     = inside_ff;
      rsp_valid_in  = 1'b0;
      rsp_inside_in = rsp_inside_ff;
      vcount_in     = vcount_ff;
      if (csr_valid && csr_ready) begin
         if (int'(csr_vertex_count) > MAX_VERTICES) begin
            vcount_in = IDX_W'(MAX_VERTICES);
         end else begin
            vcount_in = IDX_W'(csr_vertex_count);
         end
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_type == REQ_QUERY)) begin
               inside_in = 1'b0;
               idx_in    = IDX_W'(1);
               if (vcount_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_inside_in = 1'b0;
               end else begin
                  state_in = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            state_in = ST_MUL1;
            if (!last_edge) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            inside_in = inside_ff ^ toggle;
            if (last_ff) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_inside_in = inside_ff ^ toggle;
            end else begin
               state_in = ST_EDGE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         vcount_ff     <= IDX_W'(VCOUNT_RESET);
         inside_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_inside_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         vcount_ff     <= vcount_in;
         inside_ff     <= inside_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_inside_ff <= rsp_inside_in;
      end
   end

   // edge datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               px_ff <= req_coord_x;
               py_ff <= req_coord_y;
            end
         end
         ST_FIRST: begin
            first_x_ff <= rd_x;
            first_y_ff <= rd_y;
            prev_x_ff  <= rd_x;
            prev_y_ff  <= rd_y;
         end
         ST_EDGE: begin
            a_ff      <= $signed({px_ff[CW-1], px_ff}) - $signed({prev_x_ff[CW-1], prev_x_ff});
            b_ff      <= $signed({cur_y[CW-1], cur_y}) - $signed({prev_y_ff[CW-1], prev_y_ff});
            c_ff      <= $signed({py_ff[CW-1], py_ff}) - $signed({prev_y_ff[CW-1], prev_y_ff});
            d_ff      <= $signed({cur_x[CW-1], cur_x}) - $signed({prev_x_ff[CW-1], prev_x_ff});
            span_ff   <= (py_ff > ylo) && (py_ff <= yhi) && (px_ff <= xhi);
            vert_ff   <= (prev_x_ff == cur_x);
            dypos_ff  <= (cur_y > prev_y_ff);
            last_ff   <= last_edge;
            prev_x_ff <= cur_x;
            prev_y_ff <= cur_y;
         end
         ST_MUL1: begin
            p1_ff <= mul_out;
         end
         ST_MUL2: begin
            p2_ff <= mul_out;
         end
         default: begin
         end
      endcase
   end

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_DECIDE)
                       || ($past(state_ff) == ST_IDLE && $past(start)))
      else $error("result strobe without a finished query");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> (idx_ff <= vcount_ff) && (idx_ff != '0))
      else $error("edge index out of range during a query");

   a_first_after_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIRST) |-> ($past(state_ff) == ST_IDLE))
      else $error("first vertex fetch not entered from idle");

   a_flag_changes: assert property (@(posedge clock) disable iff (reset)
      (inside_ff != $past(inside_ff)) |->
         ($past(state_ff) == ST_DECIDE) || ($past(state_ff) == ST_IDLE))
      else $error("inside flag changed outside an edge decision");

   a_no_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy || $past(state_ff) == ST_IDLE)
      else $error("result strobe while a walk is in progress");

endmodule

// ===== sim/pip_crossing_checker.sv =====
// checker for point_in_polygon_test: watches the request, result and register
// channels, keeps its own vertex table and count, and checks every inside answer
// depends on pip_pkg

module pip_crossing_checker #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_type,
   input  logic [pip_pkg::SLOT_W-1:0]    req_vertex_index,
   input  logic signed [COORD_BITS-1:0]  req_coord_x,
   input  logic signed [COORD_BITS-1:0]  req_coord_y,
   input  logic                          rsp_valid,
   input  logic                          rsp_inside_res,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [pip_pkg::CSR_W-1:0]     csr_vertex_count,
   output int                            fail_count,
   output int                            pending_count,
   output int                            answer_count
);
   import pip_pkg::*;

   longint           vert_x [MAX_VERTICES];
   longint           vert_y [MAX_VERTICES];
   logic [CSR_W-1:0] poly_size;
   bit               inside_expect_q[$];
   bit               want;

   // half-open span in y, point left of or on the crossing
   function automatic bit side_crosses_ray(longint px, longint py, longint x1, longint y1,
                                           longint x2, longint y2);
      longint lo_y, hi_y, hi_x, dy, lhs, rhs;
      lo_y = (y1 < y2) ? y1 : y2;
      hi_y = (y1 < y2) ? y2 : y1;
      hi_x = (x1 < x2) ? x2 : x1;
      if (py <= lo_y || py > hi_y || px > hi_x) return 1'b0;
      if (x1 == x2) return 1'b1;
      dy  = y2 - y1;
      lhs = (px - x1) * dy;
      rhs = (py - y1) * (x2 - x1);
      return (dy > 0) ? (lhs <= rhs) : (lhs >= rhs);
   endfunction

   function automatic bit ray_parity(longint px, longint py);
      int n;
      int j;
      bit odd;
      n   = (poly_size > MAX_VERTICES) ? MAX_VERTICES : int'(poly_size);
      odd = 1'b0;
      for (int i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         if (side_crosses_ray(px, py, vert_x[i], vert_y[i], vert_x[j], vert_y[j]))
            odd = ~odd;
      end
      return odd;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         poly_size = VCOUNT_RESET;
         inside_expect_q.delete();
      end else begin
         if (rsp_valid) begin
            answer_count++;
            if (inside_expect_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual %0b",
                        $time, rsp_inside_res);
            end else begin
               want = inside_expect_q.pop_front();
               if (rsp_inside_res !== want) begin
                  fail_count++;
                  $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                           $time, want, rsp_inside_res);
               end
            end
         end
         if (csr_valid && csr_ready)
            poly_size = csr_vertex_count;
         if (start && !busy) begin
            if (req_type == REQ_WRITE) begin
               vert_x[req_vertex_index] = req_coord_x;
               vert_y[req_vertex_index] = req_coord_y;
            end else begin
               inside_expect_q = {inside_expect_q, ray_parity(req_coord_x, req_coord_y)};
            end
         end
      end
      pending_count = inside_expect_q.size();
   end

endmodule

// ===== sim/point_in_polygon_test_tb.sv =====
// testbench top for point_in_polygon_test: drives vertex writes, point queries
// and vertex count settings in random bursts; answers are checked by pip_crossing_checker
// depends on pip_pkg, point_in_polygon_test and pip_crossing_checker

module point_in_polygon_test_tb;
   import pip_pkg::*;

   localparam int MAX_VERTICES = 16;
   localparam int COORD_BITS   = 24;
   localparam int CLOCK_PERIOD = 12;
   localparam int QUERY_CYCLES = 2 + 4 * MAX_VERTICES;
   localparam int TARGET_ITEMS = 1050;
   localparam int FULL_SPAN    = 1 << (COORD_BITS - 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam coord_type COORD_MIN = coord_type'(-FULL_SPAN);
   localparam coord_type COORD_MAX = coord_type'(FULL_SPAN - 1);

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_type;
   logic [SLOT_W-1:0] req_vertex_index;
   coord_type         req_coord_x;
   coord_type         req_coord_y;
   logic              rsp_valid;
   logic              rsp_inside_res;
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_vertex_count;
   int                fail_count;
   int                pending_count;
   int                answer_count;
   int                sent_count;
   int                setting_count;
   int                burst_left;
   coord_type         poly_x [MAX_VERTICES];
   coord_type         poly_y [MAX_VERTICES];

   point_in_polygon_test #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_inside_res   (rsp_inside_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_vertex_count (csr_vertex_count)
   );

   pip_crossing_checker #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_inside_res   (rsp_inside_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_vertex_count (csr_vertex_count),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .answer_count     (answer_count)
   );

   always begin
      clock = 1'b0;
      #(CLOCK_PERIOD / 2);
      clock = 1'b1;
      #(CLOCK_PERIOD / 2);
   end

   function automatic coord_type pick_coord(int span);
      if (span >= FULL_SPAN) return coord_type'($urandom);
      return coord_type'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic send_request(logic kind, int slot, coord_type x, coord_type y);
      int gap;
      start            <= 1'b1;
      req_type         <= kind;
      req_vertex_index <= SLOT_W'(slot);
      req_coord_x      <= x;
      req_coord_y      <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   task automatic put_vertex(int slot, coord_type x, coord_type y);
      poly_x[slot] = x;
      poly_y[slot] = y;
      send_request(REQ_WRITE, slot, x, y);
   endtask

   // block goes idle once every query has answered
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_vertex_count(int n);
      csr_valid        <= 1'b1;
      csr_vertex_count <= CSR_W'(n);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   task automatic random_polygon();
      int count;
      int n;
      int span;
      int queries;
      int pick;
      int a;
      int b;
      int c;
      coord_type qx;
      coord_type qy;
      case ($urandom_range(0, 15))
         0: count = 0;
         1: count = 1;
         2: count = 2;
         3: count = MAX_VERTICES;
         4: count = ($urandom_range(0, 1) == 0) ? (1 << CSR_W) - 1
                                                : $urandom_range(MAX_VERTICES + 1, (1 << CSR_W) - 2);
         default: count = $urandom_range(3, MAX_VERTICES);
      endcase
      n = (count > MAX_VERTICES) ? MAX_VERTICES : count;
      case ($urandom_range(0, 4))
         0, 1: span = 16;
         2: span = 4096;
         3: span = 1 << 20;
         default: span = FULL_SPAN;
      endcase
      drain();
      set_vertex_count(count);
      for (int i = 0; i < n; i++)
         put_vertex(i, pick_coord(span), pick_coord(span));
      queries = $urandom_range(4, 30);
      for (int q = 0; q < queries; q++) begin
         a    = (n == 0) ? 0 : $urandom_range(0, n - 1);
         b    = (n == 0) ? 0 : $urandom_range(0, n - 1);
         c    = (a + 1 >= n) ? 0 : a + 1;
         pick = $urandom_range(0, 9);
         if (pick == 5) begin
            put_vertex($urandom_range(0, MAX_VERTICES - 1), pick_coord(span), pick_coord(span));
         end else begin
            if (n == 0 || pick == 9) begin
               qx = pick_coord(FULL_SPAN);
               qy = pick_coord(FULL_SPAN);
            end else if (pick < 3) begin
               qx = poly_x[a];
               qy = poly_y[a];
            end else if (pick < 5) begin
               qx = poly_x[a];
               qy = poly_y[b];
            end else if (pick == 6) begin
               qx = coord_type'((int'(poly_x[a]) + int'(poly_x[c])) / 2);
               qy = coord_type'((int'(poly_y[a]) + int'(poly_y[c])) / 2);
            end else begin
               qx = pick_coord(span);
               qy = pick_coord(span);
            end
            send_request(REQ_QUERY, $urandom_range(0, MAX_VERTICES - 1), qx, qy);
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_type         = REQ_WRITE;
      req_vertex_index = '0;
      req_coord_x      = '0;
      req_coord_y      = '0;
      csr_valid        = 1'b0;
      csr_vertex_count = VCOUNT_RESET;
      sent_count       = 0;
      setting_count    = 0;
      burst_left       = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // square with vertical and horizontal sides
      set_vertex_count(4);
      put_vertex(0, coord_type'(-1024), coord_type'(-1024));
      put_vertex(1, coord_type'(1024), coord_type'(-1024));
      put_vertex(2, coord_type'(1024), coord_type'(1024));
      put_vertex(3, coord_type'(-1024), coord_type'(1024));
      send_request(REQ_QUERY, 0, coord_type'(0), coord_type'(0));
      send_request(REQ_QUERY, 0, coord_type'(2048), coord_type'(0));
      send_request(REQ_QUERY, 0, coord_type'(-1024), coord_type'(0));
      send_request(REQ_QUERY, 0, coord_type'(1024), coord_type'(0));
      send_request(REQ_QUERY, 0, coord_type'(0), coord_type'(1024));
      send_request(REQ_QUERY, 0, coord_type'(0), coord_type'(-1024));
      send_request(REQ_QUERY, 0, COORD_MIN, coord_type'(0));
      send_request(REQ_QUERY, 0, COORD_MAX, COORD_MAX);

      // triangle spanning the full coordinate range
      drain();
      set_vertex_count(3);
      put_vertex(0, COORD_MIN, COORD_MIN);
      put_vertex(1, COORD_MAX, COORD_MIN);
      put_vertex(2, coord_type'(0), COORD_MAX);
      send_request(REQ_QUERY, 0, coord_type'(0), coord_type'(0));
      send_request(REQ_QUERY, 0, COORD_MIN, COORD_MIN);
      send_request(REQ_QUERY, 0, COORD_MAX, COORD_MAX);
      send_request(REQ_QUERY, 0, coord_type'(-1), COORD_MAX);

      // zero count, then a single vertex
      drain();
      set_vertex_count(0);
      send_request(REQ_QUERY, 0, coord_type'(0), coord_type'(0));
      drain();
      set_vertex_count(1);
      put_vertex(MAX_VERTICES - 1, COORD_MAX, COORD_MIN);
      send_request(REQ_QUERY, 0, COORD_MIN, COORD_MIN);

      while (sent_count < TARGET_ITEMS)
         random_polygon();

      drain();
      repeat (QUERY_CYCLES) @(posedge clock);
      $display("covered %0d requests over %0d vertex count settings, %0d answers checked",
               sent_count, setting_count, answer_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(CLOCK_PERIOD * 800000);
      $display("Verification failed");
      $finish;
   end

endmodule
